### rtl/core/lsi_pkg.sv
package lsi_pkg;

  // Field and state widths
  localparam int unsigned ModeW  = 5;
  localparam int unsigned SelW   = 2;
  localparam int unsigned LampW  = 3;
  localparam int unsigned TicksW = 16;
  localparam int unsigned UnitW  = 6;
  localparam int unsigned CountW = 22;

  // Operation codes
  localparam logic OP_SET_MODE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // Configuration register indexes
  localparam logic REG_LED_ENABLE = 1'b0;
  localparam logic REG_TICKS      = 1'b1;

  // Indication modes
  localparam logic [ModeW-1:0] MODE_IDLE        = 5'd0;
  localparam logic [ModeW-1:0] MODE_SCANNING    = 5'd1;
  localparam logic [ModeW-1:0] MODE_ADVERTISING = 5'd2;
  localparam logic [ModeW-1:0] MODE_WHITELIST   = 5'd3;
  localparam logic [ModeW-1:0] MODE_SLOW        = 5'd4;
  localparam logic [ModeW-1:0] MODE_DIRECTED    = 5'd5;
  localparam logic [ModeW-1:0] MODE_BONDING     = 5'd6;
  localparam logic [ModeW-1:0] MODE_CONNECTED   = 5'd7;
  localparam logic [ModeW-1:0] MODE_SENT_OK     = 5'd8;
  localparam logic [ModeW-1:0] MODE_SEND_ERR    = 5'd9;
  localparam logic [ModeW-1:0] MODE_RECV_OK     = 5'd10;
  localparam logic [ModeW-1:0] MODE_RECV_ERR    = 5'd11;
  localparam logic [ModeW-1:0] MODE_FATAL       = 5'd12;
  localparam logic [ModeW-1:0] MODE_ALERT_0     = 5'd13;
  localparam logic [ModeW-1:0] MODE_ALERT_1     = 5'd14;
  localparam logic [ModeW-1:0] MODE_ALERT_2     = 5'd15;
  localparam logic [ModeW-1:0] MODE_ALERT_3     = 5'd16;
  localparam logic [ModeW-1:0] MODE_ALERT_OFF   = 5'd17;
  localparam logic [ModeW-1:0] MODE_USER_OFF    = 5'd18;
  localparam logic [ModeW-1:0] MODE_USER_0      = 5'd19;
  localparam logic [ModeW-1:0] MODE_USER_1      = 5'd20;
  localparam logic [ModeW-1:0] MODE_USER_2      = 5'd21;
  localparam logic [ModeW-1:0] MODE_USER_3      = 5'd22;
  localparam logic [ModeW-1:0] MODE_USER_ON     = 5'd23;

  // LED masks
  localparam logic [LampW-1:0] LED1_BIT  = 3'b010;
  localparam logic [LampW-1:0] ALERT_BIT = 3'b100;
  localparam logic [LampW-1:0] ALL_BITS  = 3'b111;

  // Durations in 100 ms units
  localparam logic [UnitW-1:0] U_SCAN_ON  = 6'd4;
  localparam logic [UnitW-1:0] U_SCAN_OFF = 6'd40;
  localparam logic [UnitW-1:0] U_ADV_ON   = 6'd2;
  localparam logic [UnitW-1:0] U_ADV_OFF  = 6'd18;
  localparam logic [UnitW-1:0] U_WL_ON    = 6'd2;
  localparam logic [UnitW-1:0] U_WL_OFF   = 6'd8;
  localparam logic [UnitW-1:0] U_DIR_ON   = 6'd2;
  localparam logic [UnitW-1:0] U_DIR_OFF  = 6'd2;
  localparam logic [UnitW-1:0] U_BOND     = 6'd1;
  localparam logic [UnitW-1:0] U_XFER_OK  = 6'd1;
  localparam logic [UnitW-1:0] U_XFER_ERR = 6'd5;
  localparam logic [UnitW-1:0] U_ALERT_0  = 6'd8;
  localparam logic [UnitW-1:0] U_ALERT_1  = 6'd6;
  localparam logic [UnitW-1:0] U_ALERT_2  = 6'd4;

  typedef struct packed {
    logic             operation;
    logic [ModeW-1:0] indication;
    logic [SelW-1:0]  selected_led;
  } lsi_item_t;

  typedef struct packed {
    logic              led_enable;
    logic [TicksW-1:0] unit_len;
  } lsi_cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]  stable_mode;
    logic [LampW-1:0]  lamp_bits;
    logic [CountW-1:0] blink_count;
    logic              blink_running;
    logic [CountW-1:0] alert_count;
    logic [CountW-1:0] alert_period;
    logic              alert_running;
  } lsi_state_t;

  typedef struct packed {
    lsi_state_t st;
    logic       refused;
  } lsi_update_t;

  // Duration in ticks, kept to the counter width
  function automatic logic [CountW-1:0] unit_ticks(logic [TicksW-1:0] tpu,
                                                   logic [UnitW-1:0] units);
    logic [TicksW+UnitW-1:0] prod;
    prod = {{UnitW{1'b0}}, tpu} * {{TicksW{1'b0}}, units};
    return prod[CountW-1:0];
  endfunction

  // Load the one-shot blink timer; zero length is refused
  function automatic lsi_update_t start_blink(lsi_state_t s, logic [TicksW-1:0] tpu,
                                              logic [UnitW-1:0] units);
    lsi_update_t       u;
    logic [CountW-1:0] t;
    t = unit_ticks(tpu, units);
    u.st = s;
    u.refused = 1'b0;
    if (t == '0) begin
      u.refused = 1'b1;
    end else begin
      u.st.blink_count = t;
      u.st.blink_running = 1'b1;
    end
    return u;
  endfunction

  // Toggle the chosen LED, others off but alert, then time the phase
  function automatic lsi_update_t blink_mode(lsi_state_t s, logic [LampW-1:0] sel,
                                             logic [TicksW-1:0] tpu,
                                             logic [UnitW-1:0] on_u,
                                             logic [UnitW-1:0] off_u,
                                             logic [ModeW-1:0] mode);
    lsi_state_t       w;
    logic [UnitW-1:0] units;
    w = s;
    w.lamp_bits = w.lamp_bits & (sel | ALERT_BIT);
    if ((w.lamp_bits & sel) != '0) begin
      w.lamp_bits = w.lamp_bits & ~sel;
      units = off_u;
    end else begin
      w.lamp_bits = w.lamp_bits | sel;
      units = on_u;
    end
    w.stable_mode = mode;
    return start_blink(w, tpu, units);
  endfunction

  // Alert level: LED2 on, optionally a repeating invert timer
  function automatic lsi_update_t start_alert(lsi_state_t s, logic [TicksW-1:0] tpu,
                                              logic [UnitW-1:0] units);
    lsi_update_t       u;
    logic [CountW-1:0] t;
    t = unit_ticks(tpu, units);
    u.st = s;
    u.refused = 1'b0;
    u.st.alert_running = 1'b0;
    if (t == '0) begin
      u.refused = 1'b1;
    end else begin
      u.st.alert_period = t;
      u.st.alert_count = t;
      u.st.alert_running = 1'b1;
    end
    u.st.lamp_bits = u.st.lamp_bits | ALERT_BIT;
    return u;
  endfunction

  function automatic lsi_update_t apply_mode(lsi_state_t s, logic [ModeW-1:0] mode,
                                             logic [SelW-1:0] selected,
                                             logic [TicksW-1:0] tpu);
    lsi_update_t      u;
    logic [LampW-1:0] sel;
    sel = (selected == 2'd3) ? '0 : LampW'(1 << selected);
    u.st = s;
    u.refused = 1'b0;
    case (mode)
      MODE_IDLE: begin
        u.st.lamp_bits = s.lamp_bits & ALERT_BIT;
        u.st.stable_mode = mode;
      end
      MODE_SCANNING:    u = blink_mode(s, sel, tpu, U_SCAN_ON, U_SCAN_OFF, mode);
      MODE_ADVERTISING: u = blink_mode(s, sel, tpu, U_ADV_ON, U_ADV_OFF, mode);
      MODE_WHITELIST:   u = blink_mode(s, sel, tpu, U_WL_ON, U_WL_OFF, mode);
      MODE_SLOW:        u = blink_mode(s, sel, tpu, U_SCAN_ON, U_SCAN_OFF, mode);
      MODE_DIRECTED:    u = blink_mode(s, sel, tpu, U_DIR_ON, U_DIR_OFF, mode);
      MODE_BONDING:     u = blink_mode(s, sel, tpu, U_BOND, U_BOND, mode);
      MODE_CONNECTED: begin
        u.st.lamp_bits = (s.lamp_bits & (sel | ALERT_BIT)) | sel;
        u.st.stable_mode = mode;
      end
      MODE_SENT_OK, MODE_RECV_OK: begin
        u.st.lamp_bits = s.lamp_bits ^ LED1_BIT;
        u = start_blink(u.st, tpu, U_XFER_OK);
      end
      MODE_SEND_ERR, MODE_RECV_ERR: begin
        u.st.lamp_bits = s.lamp_bits ^ LED1_BIT;
        u = start_blink(u.st, tpu, U_XFER_ERR);
      end
      MODE_FATAL: u.st.lamp_bits = ALL_BITS;
      MODE_ALERT_0: u = start_alert(s, tpu, U_ALERT_0);
      MODE_ALERT_1: u = start_alert(s, tpu, U_ALERT_1);
      MODE_ALERT_2: u = start_alert(s, tpu, U_ALERT_2);
      MODE_ALERT_3: begin
        u.st.alert_running = 1'b0;
        u.st.lamp_bits = s.lamp_bits | ALERT_BIT;
      end
      MODE_ALERT_OFF: begin
        u.st.alert_running = 1'b0;
        u.st.lamp_bits = s.lamp_bits & ~ALERT_BIT;
      end
      MODE_USER_OFF: begin
        u.st.lamp_bits = '0;
        u.st.stable_mode = mode;
      end
      MODE_USER_0: begin
        u.st.lamp_bits = sel;
        u.st.stable_mode = mode;
      end
      MODE_USER_1: begin
        u.st.lamp_bits = LED1_BIT;
        u.st.stable_mode = mode;
      end
      MODE_USER_2: begin
        u.st.lamp_bits = sel | LED1_BIT;
        u.st.stable_mode = mode;
      end
      MODE_USER_3, MODE_USER_ON: begin
        u.st.lamp_bits = ALL_BITS;
        u.st.stable_mode = mode;
      end
      default: ;
    endcase
    return u;
  endfunction

endpackage

### rtl/core/lsi_engine.sv
module lsi_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  lsi_pkg::lsi_item_t              item,
  input  lsi_pkg::lsi_cfg_t               cfg,
  output logic [lsi_pkg::LampW-1:0]       led_bits_next,
  output logic                            status_next
);
  import lsi_pkg::*;

  lsi_state_t  st;
  lsi_update_t upd;
  lsi_update_t re;
  lsi_state_t  w;

  // Next state for the item held in the input register
  always_comb begin
    upd.st = st;
    upd.refused = 1'b0;
    w = st;
    re = '0;
    if (item.operation == OP_SET_MODE) begin
      if (cfg.led_enable) begin
        upd = apply_mode(st, item.indication, item.selected_led, cfg.unit_len);
      end
    end else begin
      // blink timer first, stable mode reapplied on expiry
      if (w.blink_running) begin
        if (w.blink_count != '0) begin
          w.blink_count = w.blink_count - 1'b1;
        end
        if (w.blink_count == '0) begin
          w.blink_running = 1'b0;
          if (cfg.led_enable) begin
            re = apply_mode(w, w.stable_mode, item.selected_led, cfg.unit_len);
            w = re.st;
            upd.refused = re.refused;
          end
        end
      end
      // repeating alert invert
      if (w.alert_running) begin
        if (w.alert_count != '0) begin
          w.alert_count = w.alert_count - 1'b1;
        end
        if (w.alert_count == '0) begin
          w.lamp_bits = w.lamp_bits ^ ALERT_BIT;
          w.alert_count = w.alert_period;
          if (w.alert_period == '0) begin
            w.alert_running = 1'b0;
          end
        end
      end
      upd.st = w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= upd.st;
    end
  end

  assign led_bits_next = upd.st.lamp_bits;
  assign status_next   = upd.refused;

  // A running timer never sits at zero
  a_blink_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.blink_running |-> (st.blink_count != '0))
    else $error("blink timer running with zero count");

  a_alert_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.alert_running |-> (st.alert_count != '0 && st.alert_period != '0))
    else $error("alert timer running with zero count or period");

  // Mode beats do nothing while LEDs are disabled
  a_disabled_hold: assert property (@(posedge clk) disable iff (rst)
    (step && item.operation == OP_SET_MODE && !cfg.led_enable) |=> $stable(st))
    else $error("mode beat changed state with LEDs disabled");

endmodule

### rtl/core/led_status_indicator.sv
// Channel  Handshake             Payload
// in       in_valid / in_stall   operation, indication, selected_led
// out      out_valid / out_stall led_bits, status
// config   write_enable          reg_index, write_data
//
// One beat per clock sustained while out_stall is low; a result passes from the input register
// through the update logic into the result register.
// The LED state register updates as each beat leaves the input register.
// Synchronous active-high reset clears the LED and timer state and both valid flags.
// out_stall holds the result; the input register still takes a beat while it is empty.
module led_status_indicator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [lsi_pkg::ModeW-1:0]     indication,
  input  logic [lsi_pkg::SelW-1:0]      selected_led,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsi_pkg::LampW-1:0]     led_bits,
  output logic                          status,
  input  logic                          write_enable,
  input  logic                          reg_index,
  input  logic [lsi_pkg::TicksW-1:0]    write_data
);
  import lsi_pkg::*;

  logic             in_full;
  lsi_item_t        item;
  lsi_cfg_t         cfg;
  logic             advance;
  logic [LampW-1:0] led_bits_next;
  logic             status_next;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_enable) begin
      case (reg_index)
        REG_LED_ENABLE: cfg.led_enable <= write_data[0];
        REG_TICKS:      cfg.unit_len <= write_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{operation: operation, indication: indication,
                selected_led: selected_led};
    end
  end

  lsi_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (item),
    .cfg           (cfg),
    .led_bits_next (led_bits_next),
    .status_next   (status_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_bits <= led_bits_next;
      status   <= status_next;
    end
  end

endmodule
